>>> hw/rtl/palette_fade_engine_core_assert.svh
// Assertion helpers for the palette fade engine.
// Both sample on the rising clock edge and stay quiet while reset is high.
`ifndef PALETTE_FADE_ENGINE_CORE_ASSERT_SVH
`define PALETTE_FADE_ENGINE_CORE_ASSERT_SVH

// Same-cycle implication
`define PFE_ASSERT_IMPL(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("palette fade engine check failed");

// Next-cycle implication
`define PFE_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("palette fade engine check failed");

`endif

>>> hw/rtl/palfade_pkg.sv
`timescale 1ns / 1ps

package palfade_pkg;

   // Beat field widths
   localparam int CMD_BITS      = 3;
   localparam int INDEX_BITS    = 8;
   localparam int COLOR_BITS    = 6;
   localparam int REQ_DATA_BITS = 32;
   localparam int RSP_DATA_BITS = 24;
   // Result: three colors plus the settled flag on top
   localparam int RES_BITS      = 3 * COLOR_BITS + 1;
   localparam int SETTLED_BIT   = 3 * COLOR_BITS;

   typedef enum logic [CMD_BITS-1:0] {
      CMD_WRITE    = 3'd0,
      CMD_READ     = 3'd1,
      CMD_SAVE     = 3'd2,
      CMD_FADE_OUT = 3'd3,
      CMD_FADE_IN  = 3'd4
   } cmd_type;

   typedef enum logic {
      FADE_DOWN = 1'b0,
      FADE_UP   = 1'b1
   } fade_mode_type;

endpackage

>>> hw/rtl/palette_fade_engine_core.sv
`timescale 1ns / 1ps
// Palette store with fade-out / fade-in stepping for a VGA-style DAC.
// Request channel (req_): one beat per command; tuser holds the command, tdata the entry
// index and the red/green/blue values for a write. Response channel (rsp_): exactly one
// beat per command, carrying read colors and the settled flag of a fade step.
// Live and saved palettes sit in two single-port-write RAMs with registered reads.
// A write or unknown command goes from ST_START straight to ST_POST, a read adds ST_READ,
// and save / fade-out / fade-in sweep all entries in ST_SWEEP. A sweep reads entry
// n+1 while it writes entry n back, one entry per cycle, so a full fade step occupies the
// live RAM port for every entry in turn.
// One command is worked on at a time; req_tready is high only while idle and rises with
// rsp_tvalid. A finished response waits in the output register; the next command is taken
// meanwhile, and its own result holds until the output register frees up.
// Reset: a clearing pass over every entry zeroes both palettes; req_tready stays low until
// it ends. rsp_tvalid drops at reset.
module palette_fade_engine_core #(
   parameter int ENTRY_COUNT  = 256
) (
   input  logic                                   clock,
   input  logic                                   reset,
   // req_tdata: entry_index[7:0], red_in[13:8], green_in[19:14], blue_in[25:20]
   input  logic [palfade_pkg::REQ_DATA_BITS-1:0]  req_tdata,
   // req_tuser: cmd[2:0]
   input  logic [palfade_pkg::CMD_BITS-1:0]       req_tuser,
   input  logic                                   req_tvalid,
   output logic                                   req_tready,
   // rsp_tdata: red_out[5:0], green_out[11:6], blue_out[17:12], settled[18]
   output logic [palfade_pkg::RSP_DATA_BITS-1:0]  rsp_tdata,
   output logic                                   rsp_tvalid,
   input  logic                                   rsp_tready
);

   import palfade_pkg::*;

   localparam int CHANNEL_BITS = COLOR_BITS;
   localparam int ADDR_BITS  = $clog2(ENTRY_COUNT);
   localparam int ENTRY_BITS = 3 * CHANNEL_BITS;
   localparam logic [ADDR_BITS-1:0] LAST_ADDR = ADDR_BITS'(ENTRY_COUNT - 1);

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_START,
      ST_READ,
      ST_SWEEP,
      ST_POST
   } state_type;

   state_type                 state_ff, state_in;
   cmd_type                   cmd_ff, cmd_in;
   logic [INDEX_BITS-1:0]     idx_ff, idx_in;
   logic [ENTRY_BITS-1:0]     wdata_ff, wdata_in;
   logic [ADDR_BITS-1:0]      addr_ff, addr_in;
   logic                      chg_ff, chg_in;
   logic [RES_BITS-1:0]       res_ff, res_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_BITS-1:0]  rsp_data_ff, rsp_data_in;

   logic                      live_we, saved_we;
   logic [ADDR_BITS-1:0]      live_waddr, rd_addr;
   logic [ENTRY_BITS-1:0]     live_wdata, saved_wdata;
   logic [ENTRY_BITS-1:0]     live_rdata, saved_rdata;
   logic [ENTRY_BITS-1:0]     fade_entry;
   logic                      fade_chg;
   logic                      idx_ok;
   logic                      out_free;
   fade_mode_type             fade_mode;

   // Storage
   palfade_ram #(.WIDTH(ENTRY_BITS), .DEPTH(ENTRY_COUNT)) u_live_ram (
      .clock   (clock),
      .wr_en   (live_we),
      .wr_addr (live_waddr),
      .wr_data (live_wdata),
      .rd_addr (rd_addr),
      .rd_data (live_rdata)
   );

   palfade_ram #(.WIDTH(ENTRY_BITS), .DEPTH(ENTRY_COUNT)) u_saved_ram (
      .clock   (clock),
      .wr_en   (saved_we),
      .wr_addr (addr_ff),
      .wr_data (saved_wdata),
      .rd_addr (rd_addr),
      .rd_data (saved_rdata)
   );

   // Per-entry fade arithmetic
   assign fade_mode = (cmd_ff == CMD_FADE_IN) ? FADE_UP : FADE_DOWN;

   palfade_fade #(.CHANNEL_BITS(CHANNEL_BITS)) u_fade (
      .mode        (fade_mode),
      .live_entry  (live_rdata),
      .saved_entry (saved_rdata),
      .next_entry  (fade_entry),
      .changed     (fade_chg)
   );

   assign idx_ok   = {24'd0, idx_ff} < 32'(ENTRY_COUNT);
   assign out_free = !rsp_valid_ff || rsp_tready;

   // Sequencer
   always_comb begin
      state_in     = state_ff;
      cmd_in       = cmd_ff;
      idx_in       = idx_ff;
      wdata_in     = wdata_ff;
      addr_in      = addr_ff;
      chg_in       = chg_ff;
      res_in       = res_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      live_we      = 1'b0;
      saved_we     = 1'b0;
      live_waddr   = addr_ff;
      live_wdata   = '0;
      saved_wdata  = live_rdata;
      rd_addr      = addr_ff + 1'b1;

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_CLEAR: begin
            live_we     = 1'b1;
            saved_we    = 1'b1;
            saved_wdata = '0;
            if (addr_ff == LAST_ADDR) begin
               addr_in  = '0;
               state_in = ST_IDLE;
            end else begin
               addr_in = addr_ff + 1'b1;
            end
         end
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd_in   = cmd_type'(req_tuser);
               idx_in   = req_tdata[7:0];
               wdata_in = {CHANNEL_BITS'(req_tdata[25:20]),
                           CHANNEL_BITS'(req_tdata[19:14]),
                           CHANNEL_BITS'(req_tdata[13:8])};
               addr_in  = '0;
               chg_in   = 1'b0;
               state_in = ST_START;
            end
         end
         ST_START: begin
            // Issue the first read: the addressed entry, or entry 0 for a sweep
            rd_addr = (cmd_ff == CMD_READ) ? ADDR_BITS'(idx_ff) : '0;
            res_in  = '0;
            case (cmd_ff)
               CMD_WRITE: begin
                  if (idx_ok) begin
                     live_we    = 1'b1;
                     live_waddr = ADDR_BITS'(idx_ff);
                     live_wdata = wdata_ff;
                  end
                  state_in = ST_POST;
               end
               CMD_READ: begin
                  state_in = ST_READ;
               end
               CMD_SAVE, CMD_FADE_OUT, CMD_FADE_IN: begin
                  state_in = ST_SWEEP;
               end
               default: begin
                  state_in = ST_POST;
               end
            endcase
         end
         ST_READ: begin
            if (idx_ok) begin
               res_in = {1'b0,
                         COLOR_BITS'(live_rdata[3*CHANNEL_BITS-1:2*CHANNEL_BITS]),
                         COLOR_BITS'(live_rdata[2*CHANNEL_BITS-1:CHANNEL_BITS]),
                         COLOR_BITS'(live_rdata[CHANNEL_BITS-1:0])};
            end
            state_in = ST_POST;
         end
         ST_SWEEP: begin
            // Write back entry addr_ff while entry addr_ff+1 is read
            if (cmd_ff == CMD_SAVE) begin
               saved_we = 1'b1;
            end else begin
               live_we    = 1'b1;
               live_wdata = fade_entry;
               chg_in     = chg_ff | fade_chg;
            end
            if (addr_ff == LAST_ADDR) begin
               addr_in  = '0;
               res_in   = {(cmd_ff != CMD_SAVE) && !(chg_ff | fade_chg),
                           {(3*COLOR_BITS){1'b0}}};
               state_in = ST_POST;
            end else begin
               addr_in = addr_ff + 1'b1;
            end
         end
         ST_POST: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = RSP_DATA_BITS'(res_ff);
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         addr_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         addr_ff      <= addr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cmd_ff      <= cmd_in;
      idx_ff      <= idx_in;
      wdata_ff    <= wdata_in;
      chg_ff      <= chg_in;
      res_ff      <= res_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

>>> hw/rtl/palfade_ram.sv
`timescale 1ns / 1ps

module palfade_ram #(
   parameter int WIDTH = 18,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // One write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hw/rtl/palfade_fade.sv
`timescale 1ns / 1ps

module palfade_fade #(
   parameter int CHANNEL_BITS = 6
) (
   input  palfade_pkg::fade_mode_type  mode,
   input  logic [3*CHANNEL_BITS-1:0]   live_entry,
   input  logic [3*CHANNEL_BITS-1:0]   saved_entry,
   output logic [3*CHANNEL_BITS-1:0]   next_entry,
   output logic                        changed
);

   import palfade_pkg::*;

   // One fade step on the three channels of an entry
   always_comb begin
      logic [CHANNEL_BITS-1:0] cur;
      logic [CHANNEL_BITS-1:0] sav;
      next_entry = live_entry;
      changed    = 1'b0;
      for (int c = 0; c < 3; c++) begin
         cur = live_entry[c*CHANNEL_BITS +: CHANNEL_BITS];
         sav = saved_entry[c*CHANNEL_BITS +: CHANNEL_BITS];
         if (mode == FADE_UP) begin
            if (cur < sav) begin
               next_entry[c*CHANNEL_BITS +: CHANNEL_BITS] = cur + 1'b1;
               changed = 1'b1;
            end
         end else begin
            if (cur != '0) begin
               next_entry[c*CHANNEL_BITS +: CHANNEL_BITS] = cur - 1'b1;
               changed = 1'b1;
            end
         end
      end
   end

endmodule

>>> hw/rtl/palfade_check.sv
`timescale 1ns / 1ps
`include "palette_fade_engine_core_assert.svh"

module palfade_check (
   input logic                                   clock,
   input logic                                   reset,
   input logic [palfade_pkg::REQ_DATA_BITS-1:0]  req_tdata,
   input logic [palfade_pkg::CMD_BITS-1:0]       req_tuser,
   input logic                                   req_tvalid,
   input logic                                   req_tready,
   input logic [palfade_pkg::RSP_DATA_BITS-1:0]  rsp_tdata,
   input logic                                   rsp_tvalid,
   input logic                                   rsp_tready
);

   import palfade_pkg::*;

   logic       req_beat, rsp_beat;
   logic [1:0] cnt_ff, cnt_in;

   assign req_beat = req_tvalid && req_tready;
   assign rsp_beat = rsp_tvalid && rsp_tready;

   // Commands taken but not yet answered
   assign cnt_in = cnt_ff + 2'(req_beat) - 2'(rsp_beat);

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   `PFE_ASSERT_NEXT(a_rsp_hold, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata))
   `PFE_ASSERT_NEXT(a_one_cmd, req_beat, !req_tready)
   `PFE_ASSERT_IMPL(a_rsp_owed, rsp_tvalid, cnt_ff != 2'd0)
   `PFE_ASSERT_IMPL(a_backlog, req_tready, cnt_ff <= 2'd1)
   `PFE_ASSERT_IMPL(a_settled_blank, rsp_tvalid && rsp_tdata[SETTLED_BIT],
                    rsp_tdata[SETTLED_BIT-1:0] == '0)

endmodule

bind palette_fade_engine_core palfade_check u_palfade_check (
   .clock      (clock),
   .reset      (reset),
   .req_tdata  (req_tdata),
   .req_tuser  (req_tuser),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready)
);

>>> dv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
   import palfade_pkg::*;

   localparam int ENTRIES     = 256;
   localparam int ITEM_TARGET = 450;
   localparam int QUIET_ITEMS = 50;
   localparam int MAX_REPORTS = 10;
   // Latency of a full sweep plus margin
   localparam int DRAIN_CYCLES = ENTRIES + 64;

   // Command codes the block does not decode
   localparam logic [CMD_BITS-1:0] CMD_UNUSED_LO  = 3'd5;
   localparam logic [CMD_BITS-1:0] CMD_UNUSED_MID = 3'd6;
   localparam logic [CMD_BITS-1:0] CMD_UNUSED_HI  = 3'd7;

   // Channel 0 red, 1 green, 2 blue; matches the beat layout
   typedef logic [2:0][COLOR_BITS-1:0] rgb_type;

   typedef struct packed {
      logic    settled;
      rgb_type color;
   } shade_type;

   // Shadow of both palettes and the queue of expected response beats
   class palette_scoreboard;
      rgb_type   live_pal  [ENTRIES];
      rgb_type   saved_pal [ENTRIES];
      shade_type expected_shades[$];
      int        mismatches;
      bit        last_settled;

      function new();
         foreach (live_pal[e]) begin
            live_pal[e]  = '0;
            saved_pal[e] = '0;
         end
         mismatches   = 0;
         last_settled = 1'b0;
      endfunction

      function int pending();
         return expected_shades.size();
      endfunction

      // Apply one accepted command and queue its response
      function void note_command(logic [CMD_BITS-1:0] cmd, logic [INDEX_BITS-1:0] idx,
                                 rgb_type color);
         shade_type res;
         bit        changed;
         res     = '0;
         changed = 1'b0;
         case (cmd)
            CMD_WRITE: begin
               live_pal[idx] = color;
            end
            CMD_READ: begin
               res.color = live_pal[idx];
            end
            CMD_SAVE: begin
               saved_pal = live_pal;
            end
            CMD_FADE_OUT: begin
               foreach (live_pal[e])
                  for (int c = 0; c < 3; c++)
                     if (live_pal[e][c] != '0) begin
                        live_pal[e][c] = live_pal[e][c] - 1'b1;
                        changed = 1'b1;
                     end
               res.settled = !changed;
            end
            CMD_FADE_IN: begin
               foreach (live_pal[e])
                  for (int c = 0; c < 3; c++)
                     if (live_pal[e][c] < saved_pal[e][c]) begin
                        live_pal[e][c] = live_pal[e][c] + 1'b1;
                        changed = 1'b1;
                     end
               res.settled = !changed;
            end
            default: ;
         endcase
         last_settled = res.settled;
         expected_shades.push_back(res);
      endfunction

      function void report(string what, int want, int got);
         mismatches++;
         if (mismatches <= MAX_REPORTS)
            $display("%0t: %s expected %0d actual %0d", $realtime, what, want, got);
      endfunction

      // Compare one response beat with the oldest expectation
      function void check_shade(logic [RSP_DATA_BITS-1:0] data);
         shade_type got;
         shade_type want;
         got = data[RES_BITS-1:0];
         if (expected_shades.size() == 0) begin
            report("response beat with nothing pending, settled", 0, int'(got.settled));
            return;
         end
         want = expected_shades.pop_front();
         if (got.color[0] !== want.color[0])
            report("red_out", int'(want.color[0]), int'(got.color[0]));
         if (got.color[1] !== want.color[1])
            report("green_out", int'(want.color[1]), int'(got.color[1]));
         if (got.color[2] !== want.color[2])
            report("blue_out", int'(want.color[2]), int'(got.color[2]));
         if (got.settled !== want.settled)
            report("settled", int'(want.settled), int'(got.settled));
      endfunction
   endclass

   logic                     clock;
   logic                     reset;
   logic [REQ_DATA_BITS-1:0] req_tdata;
   logic [CMD_BITS-1:0]      req_tuser;
   logic                     req_tvalid;
   logic                     req_tready;
   logic [RSP_DATA_BITS-1:0] rsp_tdata;
   logic                     rsp_tvalid;
   logic                     rsp_tready;

   palette_scoreboard shades = new();
   int items_sent = 0;
   bit quiet      = 1'b0;

   palette_fade_engine_core #(
      .ENTRY_COUNT  (ENTRIES)
   ) i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready)
   );

   // Clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Hard stop in case the block hangs
   initial begin
      #10_000_000;
      $display("Mismatches found");
      $finish;
   end

   // Response monitor
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         shades.check_shade(rsp_tdata);
   end

   // Response backpressure: random stall bursts, with calm stretches
   initial begin
      int stall;
      int phase;
      bit calm;
      stall      = 0;
      phase      = 0;
      calm       = 1'b0;
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (phase == 0) begin
            calm  = ($urandom_range(0, 2) == 0);
            phase = 256;
         end
         phase--;
         if (stall > 0) begin
            stall--;
            rsp_tready = 1'b0;
         end else if (!quiet && !calm && $urandom_range(0, 4) == 0) begin
            stall      = $urandom_range(1, 13) - 1;
            rsp_tready = 1'b0;
         end else begin
            rsp_tready = 1'b1;
         end
      end
   end

   // One request beat; entered and left at a falling edge
   task automatic send_command(logic [CMD_BITS-1:0] cmd, logic [INDEX_BITS-1:0] idx,
                               rgb_type color);
      if (!quiet && $urandom_range(0, 5) == 0) begin
         req_tvalid = 1'b0;
         repeat ($urandom_range(1, 13)) @(negedge clock);
      end
      req_tuser  = cmd;
      req_tdata  = {{(REQ_DATA_BITS - INDEX_BITS - 3 * COLOR_BITS){1'b0}}, color, idx};
      req_tvalid = 1'b1;
      do @(posedge clock); while (!req_tready);
      shades.note_command(cmd, idx, color);
      items_sent++;
      quiet = (items_sent >= ITEM_TARGET - QUIET_ITEMS);
      @(negedge clock);
      req_tvalid = 1'b0;
   endtask

   // Mostly dim colors so fades settle within a few steps
   function automatic rgb_type random_color();
      rgb_type color;
      bit      dim;
      dim = ($urandom_range(0, 3) != 0);
      for (int c = 0; c < 3; c++)
         color[c] = dim ? COLOR_BITS'($urandom_range(0, 7))
                        : COLOR_BITS'($urandom_range(0, 63));
      return color;
   endfunction

   task automatic drain_responses();
      while (shades.pending() != 0) @(posedge clock);
      @(negedge clock);
   endtask

   // Repeat one fade direction a few times or until the palette stops moving
   task automatic fade_run(logic [CMD_BITS-1:0] cmd);
      int steps;
      bool_loop: begin
         steps = ($urandom_range(0, 5) == 0) ? 70 : $urandom_range(1, 8);
         for (int s = 0; s < steps; s++) begin
            send_command(cmd, INDEX_BITS'($urandom_range(0, 255)), random_color());
            if (shades.last_settled) disable bool_loop;
         end
      end
   endtask

   // Well-formed scene: load, usually save, fade out, fade back in, with read-backs
   task automatic fade_scene();
      logic [INDEX_BITS-1:0] idx;
      for (int w = $urandom_range(1, 8); w > 0; w--) begin
         idx = INDEX_BITS'($urandom_range(0, 255));
         send_command(CMD_WRITE, idx, random_color());
         if ($urandom_range(0, 2) == 0) send_command(CMD_READ, idx, random_color());
      end
      if ($urandom_range(0, 4) != 0)
         send_command(CMD_SAVE, INDEX_BITS'($urandom_range(0, 255)), '0);
      fade_run(CMD_FADE_OUT);
      repeat ($urandom_range(0, 2))
         send_command(CMD_READ, INDEX_BITS'($urandom_range(0, 255)), '0);
      fade_run(CMD_FADE_IN);
      repeat ($urandom_range(0, 2))
         send_command(CMD_READ, INDEX_BITS'($urandom_range(0, 255)), '0);
   endtask

   // Stray beats with any command code and full-range fields
   task automatic noise_burst();
      rgb_type color;
      repeat ($urandom_range(1, 4)) begin
         for (int c = 0; c < 3; c++) color[c] = COLOR_BITS'($urandom_range(0, 63));
         send_command(CMD_BITS'($urandom_range(0, 7)), INDEX_BITS'($urandom_range(0, 255)),
                      color);
      end
   endtask

   // Stimulus
   initial begin
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = CMD_WRITE;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed: fades on a cleared palette, extreme values, every command
      send_command(CMD_FADE_OUT, 8'd0, '0);
      send_command(CMD_FADE_IN, 8'd0, '0);
      send_command(CMD_WRITE, 8'd0, {6'd63, 6'd63, 6'd63});
      send_command(CMD_WRITE, 8'd255, {6'd63, 6'd0, 6'd63});
      send_command(CMD_WRITE, 8'd128, {6'd3, 6'd2, 6'd1});
      send_command(CMD_READ, 8'd0, '0);
      send_command(CMD_READ, 8'd255, {6'd63, 6'd63, 6'd63});
      send_command(CMD_READ, 8'd128, '0);
      send_command(CMD_READ, 8'd77, '0);
      send_command(CMD_SAVE, 8'd0, '0);
      send_command(CMD_FADE_OUT, 8'd255, '0);
      send_command(CMD_READ, 8'd0, '0);
      send_command(CMD_READ, 8'd128, '0);
      send_command(CMD_FADE_IN, 8'd0, '0);
      send_command(CMD_READ, 8'd0, '0);
      // palette back at its saved copy, so the next step moves nothing
      send_command(CMD_FADE_IN, 8'd0, '0);
      send_command(CMD_UNUSED_LO, 8'd0, '0);
      send_command(CMD_UNUSED_MID, 8'd170, {6'd21, 6'd42, 6'd21});
      send_command(CMD_UNUSED_HI, 8'd255, {6'd63, 6'd63, 6'd63});
      send_command(CMD_READ, 8'd255, '0);
      send_command(CMD_WRITE, 8'd255, '0);
      send_command(CMD_READ, 8'd255, '0);

      // Hold off until the block has answered everything
      drain_responses();

      // Random part
      while (items_sent < ITEM_TARGET) begin
         if ($urandom_range(0, 3) != 0)
            fade_scene();
         else
            noise_burst();
         if ($urandom_range(0, 14) == 0) drain_responses();
      end

      // Wait out the remaining responses, then watch for strays
      drain_responses();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (shades.mismatches == 0 && shades.pending() == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule
